// ----- hdl/estd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estd_pkg - shared types and helpers for the escaped string token decoder
// Result kinds, queue entry layout, character constants and byte functions.
// ----------------------------------------------------------------------------
package estd_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 16;
    localparam logic [POS_W-1:0] MAX_CONSUMED = 16'hFFFF;

    // queue between front and back
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = QPTR_W + 1;

    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_N = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R = 8'h72;
    localparam logic [CHAR_W-1:0] CH_T = 8'h74;
    localparam logic [CHAR_W-1:0] CH_V = 8'h76;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_END_OK    = 2'd1,
        KIND_DANGLING  = 2'd2,
        KIND_UNMATCHED = 2'd3
    } t_kind;

    // one accepted byte can cause a first result (byte or token end)
    // and a second one (end of code string)
    typedef struct packed {
        logic              has_a;
        t_kind             kind_a;
        logic [CHAR_W-1:0] char_a;
        logic              has_b;
        t_kind             kind_b;
        logic [POS_W-1:0]  cons;
    } t_entry;

    function automatic logic [CHAR_W-1:0] unescape(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        unique case (c)
            CH_A:    r = 8'd7;
            CH_B:    r = 8'd8;
            CH_F:    r = 8'd12;
            CH_N:    r = 8'd10;
            CH_R:    r = 8'd13;
            CH_T:    r = 8'd9;
            CH_V:    r = 8'd11;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        return (p < MAX_CONSUMED) ? p + POS_W'(1) : p;
    endfunction

endpackage

// ----- hdl/estd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estd_front - byte classifier and token state
// Tracks quoting mode, escapes and position; builds a queue entry for each byte that yields a result.
// ----------------------------------------------------------------------------
module estd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [estd_pkg::CHAR_W-1:0]     i_char_in,
    input  logic                            i_final_byte,
    output logic                            o_push,
    output estd_pkg::t_entry                o_entry
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_QUOTED,
        PH_UNQUOTED,
        PH_DONE
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic                         r_qd, n_qd;
    logic                         r_esc, n_esc;
    logic [estd_pkg::POS_W-1:0]   r_pos, n_pos;

    always_comb begin
        logic                         proc;
        logic [estd_pkg::CHAR_W-1:0]  q;
        t_phase                       ph;
        logic                         esc;
        logic [estd_pkg::POS_W-1:0]   pos;
        estd_pkg::t_entry             ent;

        ent  = '0;
        proc = 1'b0;
        ph   = r_phase;
        esc  = r_esc;
        pos  = r_pos;
        n_qd = r_qd;
        q    = r_qd ? estd_pkg::CH_DQUOTE : estd_pkg::CH_SQUOTE;

        unique case (r_phase)
            PH_FIRST: begin
                pos = '0;
                esc = 1'b0;
                if (i_char_in == estd_pkg::CH_SQUOTE || i_char_in == estd_pkg::CH_DQUOTE) begin
                    n_qd = (i_char_in == estd_pkg::CH_DQUOTE);
                    ph   = PH_QUOTED;
                    pos  = estd_pkg::sat_inc(pos);
                end else begin
                    ph   = PH_UNQUOTED;
                    proc = 1'b1;
                end
            end
            PH_QUOTED, PH_UNQUOTED: proc = 1'b1;
            PH_DONE: ;
            default: ;
        endcase

        if (proc) begin
            priority if (esc) begin
                ent.has_a  = 1'b1;
                ent.kind_a = estd_pkg::KIND_BYTE;
                ent.char_a = estd_pkg::unescape(i_char_in);
                esc        = 1'b0;
                pos        = estd_pkg::sat_inc(pos);
            end else if (i_char_in == estd_pkg::CH_BACKSLASH) begin
                esc = 1'b1;
                pos = estd_pkg::sat_inc(pos);
            end else if (ph == PH_QUOTED) begin
                pos       = estd_pkg::sat_inc(pos);
                ent.has_a = 1'b1;
                if (i_char_in != q) begin
                    ent.kind_a = estd_pkg::KIND_BYTE;
                    ent.char_a = i_char_in;
                end else begin
                    // closing quote counts in the length
                    ent.kind_a = estd_pkg::KIND_END_OK;
                    ph         = PH_DONE;
                end
            end else begin
                ent.has_a = 1'b1;
                if (estd_pkg::is_word_char(i_char_in)) begin
                    ent.kind_a = estd_pkg::KIND_BYTE;
                    ent.char_a = i_char_in;
                    pos        = estd_pkg::sat_inc(pos);
                end else begin
                    ent.kind_a = estd_pkg::KIND_END_OK;
                    ph         = PH_DONE;
                end
            end
        end

        ent.cons = pos;

        if (i_final_byte) begin
            if (ph == PH_QUOTED || ph == PH_UNQUOTED) begin
                ent.has_b = 1'b1;
                priority if (esc)          ent.kind_b = estd_pkg::KIND_DANGLING;
                else if (ph == PH_QUOTED)  ent.kind_b = estd_pkg::KIND_UNMATCHED;
                else                       ent.kind_b = estd_pkg::KIND_END_OK;
            end
            ph   = PH_FIRST;
            n_qd = 1'b0;
            esc  = 1'b0;
            pos  = '0;
        end

        n_phase = ph;
        n_esc   = esc;
        n_pos   = pos;
        o_entry = ent;
        o_push  = i_accept && (ent.has_a || ent.has_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_qd    <= 1'b0;
            r_esc   <= 1'b0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_qd    <= n_qd;
            r_esc   <= n_esc;
            r_pos   <= n_pos;
        end
    end

endmodule

// ----- hdl/estd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estd_fifo - short queue between classifier and result sequencer
// Register-based first-in first-out store of result entries.
// ----------------------------------------------------------------------------
module estd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  estd_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output estd_pkg::t_entry  o_head
);

    estd_pkg::t_entry               r_mem [estd_pkg::QDEPTH];
    logic [estd_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [estd_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [estd_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                           do_push, do_pop;

    localparam logic [estd_pkg::QPTR_W-1:0] LAST_PTR = estd_pkg::QPTR_W'(estd_pkg::QDEPTH - 1);
    localparam logic [estd_pkg::QCNT_W-1:0] FULL_CNT = estd_pkg::QCNT_W'(estd_pkg::QDEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

// ----- hdl/estd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estd_back - result sequencer
// Expands queue entries into one or two result transactions into an output
// register.
// ----------------------------------------------------------------------------
module estd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  estd_pkg::t_entry               i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [estd_pkg::CHAR_W-1:0]    o_char_out,
    output logic [estd_pkg::POS_W-1:0]     o_consumed,
    output logic                           o_last_of_run
);

    logic                          r_valid, n_valid;
    logic                          r_sub, n_sub;
    estd_pkg::t_kind               r_kind, n_kind;
    logic [estd_pkg::CHAR_W-1:0]   r_char, n_char;
    logic [estd_pkg::POS_W-1:0]    r_cons, n_cons;
    logic                          r_last, n_last;

    always_comb begin
        logic load;
        logic take_b;

        load    = !r_valid || i_out_ready;
        take_b  = r_sub || !i_head.has_a;
        n_valid = r_valid;
        n_sub   = r_sub;
        n_kind  = r_kind;
        n_char  = r_char;
        n_cons  = r_cons;
        n_last  = r_last;
        o_pop   = 1'b0;

        if (load) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                if (take_b) begin
                    n_kind = i_head.kind_b;
                    n_char = '0;
                    n_cons = i_head.cons;
                    n_last = 1'b1;
                    n_sub  = 1'b0;
                    o_pop  = 1'b1;
                end else begin
                    n_kind = i_head.kind_a;
                    n_char = i_head.char_a;
                    n_cons = (i_head.kind_a == estd_pkg::KIND_BYTE) ? '0 : i_head.cons;
                    n_last = !i_head.has_b;
                    // hold the entry for its second result
                    n_sub  = i_head.has_b;
                    o_pop  = !i_head.has_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
        r_kind <= n_kind;
        r_char <= n_char;
        r_cons <= n_cons;
        r_last <= n_last;
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_char_out    = r_char;
    assign o_consumed    = r_cons;
    assign o_last_of_run = r_last;

endmodule

// ----- hdl/escaped_string_token_decoder.sv -----
`timescale 1ns / 1ps
// path: an accepted byte is queued, then its result is loaded into the output register
// throughput: one byte per cycle while o_in_ready is high; a byte with two results holds
// the sequencer for both; the 4-entry queue absorbs those and output stalls until full
// reset: synchronous active low; clears token state, empties the queue, drops valid
// ----------------------------------------------------------------------------
// escaped_string_token_decoder - quoted / unquoted token decoder with escapes
// Classifier, result queue and result sequencer.
// ----------------------------------------------------------------------------
module escaped_string_token_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_char_out,
    output logic [15:0] o_consumed,
    output logic        o_last_of_run
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    estd_pkg::t_entry  entry;
    estd_pkg::t_entry  head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    estd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_in    (i_char_in),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_entry      (entry)
    );

    estd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    estd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_char_out    (o_char_out),
        .o_consumed    (o_consumed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- hdl/estd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estd_checker - port-level checks for the token decoder
// Watches both channels and the field rules of each result kind.
// ----------------------------------------------------------------------------
module estd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_final_byte,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_kind,
    input  logic [7:0]  o_char_out,
    input  logic [15:0] o_consumed,
    input  logic        o_last_of_run
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_char_in) &&
        $stable(i_final_byte))
        else $error("input changed while stalled");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_char_out) && $stable(o_consumed) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == estd_pkg::KIND_BYTE |-> o_consumed == 16'd0)
        else $error("decoded byte carries a length");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != estd_pkg::KIND_BYTE |-> o_char_out == 8'd0 && o_last_of_run)
        else $error("token end with byte data or not last");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind escaped_string_token_decoder estd_checker u_estd_checker (.*);
